FILE: rtl/dpec_pkg.sv
// ----------------------------------------------------------------------------
// dpec_pkg
// Shared widths, payload structs and helper functions for the disc pair
// elastic collision core.
// ----------------------------------------------------------------------------
package dpec_pkg;

   localparam int POS_W   = 32;
   localparam int VEL_W   = 32;
   localparam int RAD_W   = 31;
   localparam int MASS_W  = 31;

   localparam int DIFF_W  = POS_W + 1;             // signed difference
   localparam int MAG_W   = DIFF_W;                // magnitude of a difference
   localparam int SQ_W    = 2 * MAG_W;             // product of two magnitudes
   localparam int DIST_W  = SQ_W;                  // squared centre distance
   localparam int RS_W    = RAD_W + 1;             // radius sum
   localparam int RS2_W   = 2 * RS_W;
   localparam int MSUM_W  = MASS_W + 1;
   localparam int DOT_W   = SQ_W;
   localparam int DOT_LO_W = MAG_W;                // dot split for the wide product
   localparam int DOT_HI_W = DOT_W - DOT_LO_W;
   localparam int PP_W    = 2 * MAG_W;
   localparam int NUM_W   = DOT_W + MAG_W;         // dividend width of the dividers

   localparam int DIV_Q_W   = 35;                  // quotient bits, one per stage
   localparam int DIV_DEN_W = DIST_W;
   localparam int DIV_REM_W = DIV_DEN_W + DIV_Q_W;

   localparam int CH_W    = MASS_W + DIV_Q_W + 1;  // 2 * mass * projected delta
   localparam int SUM_W   = DIV_Q_W + 2;           // velocity plus signed change

   localparam int QUEUE_DEPTH = 4;                 // power of two
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [POS_W-1:0]  a_pos_x;
      logic [POS_W-1:0]  a_pos_y;
      logic [VEL_W-1:0]  a_vel_x;
      logic [VEL_W-1:0]  a_vel_y;
      logic [RAD_W-1:0]  a_radius;
      logic [MASS_W-1:0] a_mass;
      logic [POS_W-1:0]  b_pos_x;
      logic [POS_W-1:0]  b_pos_y;
      logic [VEL_W-1:0]  b_vel_x;
      logic [VEL_W-1:0]  b_vel_y;
      logic [RAD_W-1:0]  b_radius;
      logic [MASS_W-1:0] b_mass;
   } req_type;

   typedef struct packed {
      logic              collided;
      logic              degenerate;
      logic [VEL_W-1:0]  new_a_vel_x;
      logic [VEL_W-1:0]  new_a_vel_y;
      logic [VEL_W-1:0]  new_b_vel_x;
      logic [VEL_W-1:0]  new_b_vel_y;
   } rsp_type;

   // classified pair handed from the front to the back
   typedef struct packed {
      logic              collided;
      logic              degenerate;
      logic [DIST_W-1:0] dist2;
      logic [MAG_W-1:0]  mdx;
      logic [MAG_W-1:0]  mdy;
      logic              dx_neg;
      logic              dy_neg;
      logic [MAG_W-1:0]  mdvx;
      logic [MAG_W-1:0]  mdvy;
      logic              dvx_neg;
      logic              dvy_neg;
      logic [VEL_W-1:0]  a_vel_x;
      logic [VEL_W-1:0]  a_vel_y;
      logic [VEL_W-1:0]  b_vel_x;
      logic [VEL_W-1:0]  b_vel_y;
      logic [MASS_W-1:0] a_mass;
      logic [MASS_W-1:0] b_mass;
   } queue_item_type;

   // what travels beside the arithmetic in the back pipeline
   typedef struct packed {
      logic              collided;
      logic              degenerate;
      logic              respond;
      logic              xneg;
      logic              yneg;
      logic [VEL_W-1:0]  a_vel_x;
      logic [VEL_W-1:0]  a_vel_y;
      logic [VEL_W-1:0]  b_vel_x;
      logic [VEL_W-1:0]  b_vel_y;
      logic [MASS_W-1:0] a_mass;
      logic [MASS_W-1:0] b_mass;
      logic [MSUM_W-1:0] msum;
   } back_side_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [VEL_W-1:0] sat_vel(input logic [SUM_W-1:0] s);
      logic [VEL_W-1:0] r;
      if (!s[SUM_W-1] && (|s[SUM_W-2:VEL_W-1])) begin
         r = {1'b0, {(VEL_W-1){1'b1}}};
      end else if (s[SUM_W-1] && !(&s[SUM_W-2:VEL_W-1])) begin
         r = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         r = s[VEL_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/dpec_front.sv
// ----------------------------------------------------------------------------
// dpec_front
// Accepts disc pairs, forms differences and squares, and classifies each
// pair as separate, colliding or coincident before handing it to the queue.
// ----------------------------------------------------------------------------
module dpec_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dpec_pkg::req_type        req_data,
   input  logic                     q_full,
   output logic                     push,
   output dpec_pkg::queue_item_type push_item
);
   import dpec_pkg::*;

   logic                 en;
   logic [DIFF_W-1:0]    dx, dy, dvx, dvy;
   queue_item_type       f1_in, f1_ff, f2_ff, f3_in, f3_ff;
   logic [RS_W-1:0]      rs_in, rs_ff;
   logic                 f1_vld_ff, f2_vld_ff, f3_vld_ff;
   logic [SQ_W-1:0]      sqx_ff, sqy_ff;
   logic [RS2_W-1:0]     rs2_ff;
   logic [DIST_W-1:0]    dist2;

   assign en        = !(f3_vld_ff && q_full);
   assign req_stall = !en;
   assign push      = f3_vld_ff && !q_full;
   assign push_item = f3_ff;

   always_comb begin
      dx    = {req_data.a_pos_x[POS_W-1], req_data.a_pos_x}
            - {req_data.b_pos_x[POS_W-1], req_data.b_pos_x};
      dy    = {req_data.a_pos_y[POS_W-1], req_data.a_pos_y}
            - {req_data.b_pos_y[POS_W-1], req_data.b_pos_y};
      dvx   = {req_data.a_vel_x[VEL_W-1], req_data.a_vel_x}
            - {req_data.b_vel_x[VEL_W-1], req_data.b_vel_x};
      dvy   = {req_data.a_vel_y[VEL_W-1], req_data.a_vel_y}
            - {req_data.b_vel_y[VEL_W-1], req_data.b_vel_y};
      f1_in            = '0;
      f1_in.mdx        = mag_of(dx);
      f1_in.mdy        = mag_of(dy);
      f1_in.dx_neg     = dx[DIFF_W-1];
      f1_in.dy_neg     = dy[DIFF_W-1];
      f1_in.mdvx       = mag_of(dvx);
      f1_in.mdvy       = mag_of(dvy);
      f1_in.dvx_neg    = dvx[DIFF_W-1];
      f1_in.dvy_neg    = dvy[DIFF_W-1];
      f1_in.a_vel_x    = req_data.a_vel_x;
      f1_in.a_vel_y    = req_data.a_vel_y;
      f1_in.b_vel_x    = req_data.b_vel_x;
      f1_in.b_vel_y    = req_data.b_vel_y;
      f1_in.a_mass     = req_data.a_mass;
      f1_in.b_mass     = req_data.b_mass;
      rs_in = RS_W'(req_data.a_radius) + RS_W'(req_data.b_radius);
   end

   always_comb begin
      dist2            = sqx_ff + sqy_ff;
      f3_in            = f2_ff;
      f3_in.dist2      = dist2;
      // touching counts as a collision
      f3_in.collided   = dist2 <= DIST_W'(rs2_ff);
      f3_in.degenerate = (f2_ff.mdx == '0) && (f2_ff.mdy == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= req_valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff  <= f1_in;
         rs_ff  <= rs_in;
         f2_ff  <= f1_ff;
         sqx_ff <= SQ_W'(f1_ff.mdx) * SQ_W'(f1_ff.mdx);
         sqy_ff <= SQ_W'(f1_ff.mdy) * SQ_W'(f1_ff.mdy);
         rs2_ff <= RS2_W'(rs_ff) * RS2_W'(rs_ff);
         f3_ff  <= f3_in;
      end
   end

endmodule

FILE: rtl/dpec_queue.sv
// ----------------------------------------------------------------------------
// dpec_queue
// Small register queue between the classifying front and the response back.
// ----------------------------------------------------------------------------
module dpec_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dpec_pkg::queue_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output dpec_pkg::queue_item_type head_item
);
   import dpec_pkg::*;

   queue_item_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full       = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/dpec_div.sv
// ----------------------------------------------------------------------------
// dpec_div
// Pipelined restoring divider, one quotient bit per stage. The dividend must
// stay below the divisor shifted by the quotient width.
// ----------------------------------------------------------------------------
module dpec_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [dpec_pkg::NUM_W-1:0]      num,
   input  logic [dpec_pkg::DIV_DEN_W-1:0]  den,
   output logic [dpec_pkg::DIV_Q_W-1:0]    quo
);
   import dpec_pkg::*;

   logic [DIV_REM_W-1:0] rem_ff [DIV_Q_W];
   logic [DIV_DEN_W-1:0] den_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_ff [DIV_Q_W];

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
      logic [DIV_REM_W-1:0] r_cur;
      logic [DIV_DEN_W-1:0] d_cur;
      logic [DIV_Q_W-1:0]   q_cur;
      logic [DIV_REM_W-1:0] shifted;

      if (k == 0) begin : g_first
         assign r_cur = DIV_REM_W'(num);
         assign d_cur = den;
         assign q_cur = '0;
      end else begin : g_next
         assign r_cur = rem_ff[k-1];
         assign d_cur = den_ff[k-1];
         assign q_cur = quo_ff[k-1];
      end

      assign shifted = DIV_REM_W'(d_cur) << (DIV_Q_W - 1 - k);

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= d_cur;
            if (r_cur >= shifted) begin
               rem_ff[k] <= r_cur - shifted;
               quo_ff[k] <= q_cur | (DIV_Q_W'(1) << (DIV_Q_W - 1 - k));
            end else begin
               rem_ff[k] <= r_cur;
               quo_ff[k] <= q_cur;
            end
         end
      end
   end

   assign quo = quo_ff[DIV_Q_W-1];

endmodule

FILE: rtl/dpec_back.sv
// ----------------------------------------------------------------------------
// dpec_back
// Collision response: projects the relative velocity on the centre line,
// scales it by the mass ratio and updates both velocities with saturation.
// ----------------------------------------------------------------------------
module dpec_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  dpec_pkg::queue_item_type head_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dpec_pkg::rsp_type        rsp_data
);
   import dpec_pkg::*;

   function automatic logic [VEL_W-1:0] vel_update(input logic [VEL_W-1:0] v,
                                                   input logic [DIV_Q_W-1:0] ch,
                                                   input logic sub);
      logic [SUM_W-1:0] sv;
      logic [SUM_W-1:0] cv;
      sv = {{(SUM_W-VEL_W){v[VEL_W-1]}}, v};
      cv = SUM_W'(ch);
      return sat_vel(sub ? sv - cv : sv + cv);
   endfunction

   logic en;

   // stage 1: dot product terms
   back_side_type     side1_in, side1_ff;
   logic              vld1_ff;
   logic [SQ_W-1:0]   p1_ff, p2_ff;
   logic              sg1_ff, sg2_ff, dxn1_ff, dyn1_ff;
   logic [MAG_W-1:0]  mdx1_ff, mdy1_ff;
   logic [DIST_W-1:0] dist1_ff;
   logic [MSUM_W-1:0] msum;

   // stage 2: signed dot product
   back_side_type     side2_in, side2_ff;
   logic              vld2_ff;
   logic [DOT_W-1:0]  dot_in, dot2_ff;
   logic              sd;
   logic [MAG_W-1:0]  mdx2_ff, mdy2_ff;
   logic [DIST_W-1:0] dist2_ff;

   // stage 3 and 4: dot times centre offset, in two halves
   back_side_type     side3_ff, side4_ff;
   logic              vld3_ff, vld4_ff;
   logic [PP_W-1:0]   pplx_ff, pphx_ff, pply_ff, pphy_ff;
   logic [DIST_W-1:0] dist3_ff, dist4_ff;
   logic [NUM_W-1:0]  numx4_ff, numy4_ff;

   // first divider line
   back_side_type     line1_ff [DIV_Q_W];
   logic              vline1_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0] qx, qy;

   // stage 5: mass scaling
   back_side_type     side5_ff;
   logic              vld5_ff;
   back_side_type     side5_src;
   logic [CH_W-1:0]   nax5_ff, nay5_ff, nbx5_ff, nby5_ff;

   // second divider line
   back_side_type     line2_ff [DIV_Q_W];
   logic              vline2_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0] cax, cay, cbx, cby;

   back_side_type     side6;
   rsp_type           rsp_in, rsp_ff;
   logic              rsp_vld_ff;

   assign en        = !(rsp_vld_ff && rsp_stall);
   assign pop       = head_valid && en;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      msum              = MSUM_W'(head_item.a_mass) + MSUM_W'(head_item.b_mass);
      side1_in.collided   = head_item.collided;
      side1_in.degenerate = head_item.degenerate;
      side1_in.respond    = head_item.collided && !head_item.degenerate && (msum != '0);
      side1_in.xneg       = 1'b0;
      side1_in.yneg       = 1'b0;
      side1_in.a_vel_x    = head_item.a_vel_x;
      side1_in.a_vel_y    = head_item.a_vel_y;
      side1_in.b_vel_x    = head_item.b_vel_x;
      side1_in.b_vel_y    = head_item.b_vel_y;
      side1_in.a_mass     = head_item.a_mass;
      side1_in.b_mass     = head_item.b_mass;
      side1_in.msum       = msum;
   end

   always_comb begin
      if (sg1_ff == sg2_ff) begin
         dot_in = p1_ff + p2_ff;
         sd     = sg1_ff;
      end else if (p1_ff >= p2_ff) begin
         dot_in = p1_ff - p2_ff;
         sd     = sg1_ff;
      end else begin
         dot_in = p2_ff - p1_ff;
         sd     = sg2_ff;
      end
      side2_in      = side1_ff;
      side2_in.xneg = sd ^ dxn1_ff;
      side2_in.yneg = sd ^ dyn1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         p1_ff    <= SQ_W'(head_item.mdvx) * SQ_W'(head_item.mdx);
         p2_ff    <= SQ_W'(head_item.mdvy) * SQ_W'(head_item.mdy);
         sg1_ff   <= head_item.dvx_neg ^ head_item.dx_neg;
         sg2_ff   <= head_item.dvy_neg ^ head_item.dy_neg;
         dxn1_ff  <= head_item.dx_neg;
         dyn1_ff  <= head_item.dy_neg;
         mdx1_ff  <= head_item.mdx;
         mdy1_ff  <= head_item.mdy;
         dist1_ff <= head_item.dist2;

         side2_ff <= side2_in;
         dot2_ff  <= dot_in;
         mdx2_ff  <= mdx1_ff;
         mdy2_ff  <= mdy1_ff;
         dist2_ff <= dist1_ff;

         side3_ff <= side2_ff;
         pplx_ff  <= PP_W'(dot2_ff[DOT_LO_W-1:0]) * PP_W'(mdx2_ff);
         pphx_ff  <= PP_W'(dot2_ff[DOT_W-1:DOT_LO_W]) * PP_W'(mdx2_ff);
         pply_ff  <= PP_W'(dot2_ff[DOT_LO_W-1:0]) * PP_W'(mdy2_ff);
         pphy_ff  <= PP_W'(dot2_ff[DOT_W-1:DOT_LO_W]) * PP_W'(mdy2_ff);
         dist3_ff <= dist2_ff;

         side4_ff <= side3_ff;
         numx4_ff <= (NUM_W'(pphx_ff) << DOT_LO_W) + NUM_W'(pplx_ff);
         numy4_ff <= (NUM_W'(pphy_ff) << DOT_LO_W) + NUM_W'(pply_ff);
         dist4_ff <= dist3_ff;
      end
   end

   // projected delta magnitudes
   dpec_div u_div_dx (.clock(clock), .en(en), .num(numx4_ff), .den(dist4_ff), .quo(qx));
   dpec_div u_div_dy (.clock(clock), .en(en), .num(numy4_ff), .den(dist4_ff), .quo(qy));

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_line
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               line1_ff[k] <= side4_ff;
               line2_ff[k] <= side5_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vline1_ff[k] <= 1'b0;
               vline2_ff[k] <= 1'b0;
            end else if (en) begin
               vline1_ff[k] <= vld4_ff;
               vline2_ff[k] <= vld5_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               line1_ff[k] <= line1_ff[k-1];
               line2_ff[k] <= line2_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vline1_ff[k] <= 1'b0;
               vline2_ff[k] <= 1'b0;
            end else if (en) begin
               vline1_ff[k] <= vline1_ff[k-1];
               vline2_ff[k] <= vline2_ff[k-1];
            end
         end
      end
   end

   assign side5_src = line1_ff[DIV_Q_W-1];

   // change numerators: 2 * other mass * delta
   always_ff @(posedge clock) begin
      if (en) begin
         side5_ff <= side5_src;
         nax5_ff  <= (CH_W'(side5_src.b_mass) * CH_W'(qx)) << 1;
         nay5_ff  <= (CH_W'(side5_src.b_mass) * CH_W'(qy)) << 1;
         nbx5_ff  <= (CH_W'(side5_src.a_mass) * CH_W'(qx)) << 1;
         nby5_ff  <= (CH_W'(side5_src.a_mass) * CH_W'(qy)) << 1;
      end
   end

   dpec_div u_div_ax (.clock(clock), .en(en), .num(NUM_W'(nax5_ff)),
                      .den(DIV_DEN_W'(side5_ff.msum)), .quo(cax));
   dpec_div u_div_ay (.clock(clock), .en(en), .num(NUM_W'(nay5_ff)),
                      .den(DIV_DEN_W'(side5_ff.msum)), .quo(cay));
   dpec_div u_div_bx (.clock(clock), .en(en), .num(NUM_W'(nbx5_ff)),
                      .den(DIV_DEN_W'(side5_ff.msum)), .quo(cbx));
   dpec_div u_div_by (.clock(clock), .en(en), .num(NUM_W'(nby5_ff)),
                      .den(DIV_DEN_W'(side5_ff.msum)), .quo(cby));

   assign side6 = line2_ff[DIV_Q_W-1];

   always_comb begin
      rsp_in.collided   = side6.collided;
      rsp_in.degenerate = side6.degenerate;
      rsp_in.new_a_vel_x = side6.a_vel_x;
      rsp_in.new_a_vel_y = side6.a_vel_y;
      rsp_in.new_b_vel_x = side6.b_vel_x;
      rsp_in.new_b_vel_y = side6.b_vel_y;
      if (side6.respond) begin
         // disc a moves against delta, disc b along it
         rsp_in.new_a_vel_x = vel_update(side6.a_vel_x, cax, !side6.xneg);
         rsp_in.new_a_vel_y = vel_update(side6.a_vel_y, cay, !side6.yneg);
         rsp_in.new_b_vel_x = vel_update(side6.b_vel_x, cbx, side6.xneg);
         rsp_in.new_b_vel_y = vel_update(side6.b_vel_y, cby, side6.yneg);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         vld4_ff    <= 1'b0;
         vld5_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld1_ff    <= head_valid;
         vld2_ff    <= vld1_ff;
         vld3_ff    <= vld2_ff;
         vld4_ff    <= vld3_ff;
         vld5_ff    <= vline1_ff[DIV_Q_W-1];
         rsp_vld_ff <= vline2_ff[DIV_Q_W-1];
      end
   end

endmodule

FILE: rtl/disc_pair_elastic_collision_core.sv
// ----------------------------------------------------------------------------
// disc_pair_elastic_collision_core
// Elastic collision of two discs: overlap test and velocity response.
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   dpec_pkg::req_type
//   rsp       out   rsp_valid/rsp_stall   dpec_pkg::rsp_type
//
// One pair per cycle sustained while rsp_stall is low. A pair passes three
// front stages, one in the queue, and 76 back stages, set by two pipelined
// dividers of 35 single-bit stages each.
// Reset clears all valid bits and the queue; the core accepts right after.
// A stalled result freezes the back pipeline; the front keeps taking pairs
// until the four-entry queue fills, then raises req_stall.
// ----------------------------------------------------------------------------
module disc_pair_elastic_collision_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dpec_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dpec_pkg::rsp_type   rsp_data
);
   import dpec_pkg::*;

   logic           q_full, push, pop, head_valid;
   queue_item_type push_item, head_item;

   dpec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   dpec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   dpec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/dpec_checker.sv
// ----------------------------------------------------------------------------
// dpec_checker
// Port-level checks for the disc pair elastic collision core.
// ----------------------------------------------------------------------------
module dpec_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input dpec_pkg::req_type   req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input dpec_pkg::rsp_type   rsp_data
);
   import dpec_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // coincident centres always count as a collision
   a_degen_collided: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.collided)
      else $error("degenerate result without collision");

   // nothing comes out right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

   // the front is free to take a transfer right after reset
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall)
      else $error("req_stall right after reset");

endmodule

bind disc_pair_elastic_collision_core dpec_checker u_dpec_checker (.*);
